/* rtl/core/pnca_pkg.sv */
// ============================================================================
// pnca_pkg
// Shared types and constants for the pattern null-column advance core:
// command and status codes, the per-cell operation code and the word that
// travels down the chain of position cells.
// ============================================================================
package pnca_pkg;

    // Default sizing
    localparam int MAX_PATTERN_DEF  = 64;
    localparam int MAX_ALPHABET_DEF = 32;
    localparam int FRONT_BITS_DEF   = 16;

    // Fixed field widths
    localparam int CMD_W    = 2;
    localparam int SYM_W    = 5;
    localparam int DEPTH_W  = 16;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int MASK_W   = 64;
    localparam int COUNT_W  = 7;
    localparam int FVAL_W   = 16;
    localparam int LEN_W    = 7;
    localparam int ALPHA_W  = 6;
    localparam int LIMIT_W  = 9;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 6'd4;

    // Input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_BAD_SYMBOL = 2'd2,
        ST_BAD_POS    = 2'd3
    } status_t;

    // Operation carried to the cells once the head has checked the command
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_CLEAR   = 3'd1,
        OP_APPEND  = 3'd2,
        OP_ADVANCE = 3'd3,
        OP_READ    = 3'd4
    } op_t;

    // Word handed from cell to cell
    typedef struct packed {
        op_t                  op;
        logic [SYM_W-1:0]     symbol;
        logic [DEPTH_W-1:0]   depth;
        logic [POS_W-1:0]     pos;      // read position, or target cell of an append
        status_t              status;
        logic [LEN_W-1:0]     length;   // pattern length after this word
        logic [MASK_W-1:0]    mask;
        logic [COUNT_W-1:0]   count;
        logic [FVAL_W-1:0]    front;
    } word_t;

endpackage

/* rtl/core/pnca_head.sv */
// ============================================================================
// pnca_head
// Entry stage of the chain: holds the alphabet size and the pattern length,
// checks each command, and launches one word into the first cell.
// ============================================================================
module pnca_head #(
    parameter int MAX_PATTERN  = pnca_pkg::MAX_PATTERN_DEF,
    parameter int MAX_ALPHABET = pnca_pkg::MAX_ALPHABET_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         cfg_wr_en,
    input  logic [pnca_pkg::ALPHA_W-1:0] cfg_wr_data,
    input  logic                         in_valid,
    input  logic [pnca_pkg::CMD_W-1:0]   command,
    input  logic [pnca_pkg::SYM_W-1:0]   symbol,
    input  logic [pnca_pkg::DEPTH_W-1:0] depth,
    input  logic [pnca_pkg::POS_W-1:0]   position,
    output logic                         valid_out,
    output pnca_pkg::word_t              word_out
);

    logic [pnca_pkg::ALPHA_W-1:0] alpha_reg;
    logic [pnca_pkg::LEN_W-1:0]   length_reg;
    logic [pnca_pkg::LEN_W-1:0]   length_next;
    logic                         valid_reg;
    pnca_pkg::word_t              word_reg;
    pnca_pkg::word_t              word_next;
    logic                         sym_ok;
    logic                         full;

    // Symbol must be below both the configured size and the build limit
    assign sym_ok = ({4'b0, symbol} < {3'b0, alpha_reg}) &&
                    ({4'b0, symbol} < pnca_pkg::LIMIT_W'(MAX_ALPHABET));
    assign full   = (length_reg >= pnca_pkg::LEN_W'(MAX_PATTERN));

    // Check the command and build the word
    always_comb
    begin
        length_next      = length_reg;
        word_next.op     = pnca_pkg::OP_NONE;
        word_next.symbol = symbol;
        word_next.depth  = depth;
        word_next.pos    = position;
        word_next.status = pnca_pkg::ST_OK;
        word_next.mask   = '0;
        word_next.count  = '0;
        word_next.front  = '0;
        unique case (pnca_pkg::cmd_t'(command))
            pnca_pkg::CMD_CLEAR:
            begin
                word_next.op = pnca_pkg::OP_CLEAR;
                length_next  = '0;
            end
            pnca_pkg::CMD_APPEND:
            begin
                if (full)
                begin
                    word_next.status = pnca_pkg::ST_FULL;
                end
                else if (!sym_ok)
                begin
                    word_next.status = pnca_pkg::ST_BAD_SYMBOL;
                end
                else
                begin
                    word_next.op  = pnca_pkg::OP_APPEND;
                    word_next.pos = length_reg[pnca_pkg::POS_W-1:0];
                    length_next   = length_reg + 7'd1;
                end
            end
            pnca_pkg::CMD_ADVANCE:
            begin
                if (!sym_ok)
                begin
                    word_next.status = pnca_pkg::ST_BAD_SYMBOL;
                end
                else
                begin
                    word_next.op = pnca_pkg::OP_ADVANCE;
                end
            end
            pnca_pkg::CMD_READ:
            begin
                if ({1'b0, position} >= length_reg)
                begin
                    word_next.status = pnca_pkg::ST_BAD_POS;
                end
                else
                begin
                    word_next.op = pnca_pkg::OP_READ;
                end
            end
            default:
            begin
                word_next.op = pnca_pkg::OP_NONE;
            end
        endcase
        word_next.length = length_next;
    end

    // Hold configuration and pattern length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg  <= pnca_pkg::ALPHA_RESET;
            length_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                alpha_reg <= cfg_wr_data;
            end
            if (en)
            begin
                valid_reg <= in_valid;
                if (in_valid)
                begin
                    length_reg <= length_next;
                end
            end
        end
    end

    // Launch the word
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign valid_out = valid_reg;
    assign word_out  = word_reg;

endmodule

/* rtl/core/pnca_cell.sv */
// ============================================================================
// pnca_cell
// One pattern position: holds its symbol and front value, acts on the word
// passing through, and hands the word on to the next cell.
// ============================================================================
module pnca_cell #(
    parameter int INDEX      = 0,
    parameter int FRONT_BITS = pnca_pkg::FRONT_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            valid_in,
    input  pnca_pkg::word_t word_in,
    output logic            valid_out,
    output pnca_pkg::word_t word_out
);

    localparam int CMP_W = (FRONT_BITS > pnca_pkg::DEPTH_W) ? FRONT_BITS : pnca_pkg::DEPTH_W;

    logic [pnca_pkg::SYM_W-1:0] sym_reg;
    logic [pnca_pkg::SYM_W-1:0] sym_next;
    logic [FRONT_BITS-1:0]      front_reg;
    logic [FRONT_BITS-1:0]      front_next;
    logic [CMP_W-1:0]           front_ext;
    logic [CMP_W-1:0]           depth_ext;
    logic                       in_pattern;
    logic                       adv_hit;
    logic                       valid_reg;
    pnca_pkg::word_t            word_reg;
    pnca_pkg::word_t            word_next;

    assign front_ext  = CMP_W'(front_reg);
    assign depth_ext  = CMP_W'(word_in.depth);
    assign in_pattern = (pnca_pkg::LEN_W'(INDEX) < word_in.length);
    assign adv_hit    = in_pattern && (sym_reg == word_in.symbol) &&
                        (front_ext == depth_ext) && (front_reg != {FRONT_BITS{1'b1}});

    // Act on the passing word
    always_comb
    begin
        sym_next   = sym_reg;
        front_next = front_reg;
        word_next  = word_in;
        unique case (word_in.op)
            pnca_pkg::OP_CLEAR:
            begin
                front_next = '0;
            end
            pnca_pkg::OP_APPEND:
            begin
                if (word_in.pos == pnca_pkg::POS_W'(INDEX))
                begin
                    sym_next   = word_in.symbol;
                    front_next = '0;
                end
            end
            pnca_pkg::OP_ADVANCE:
            begin
                if (adv_hit)
                begin
                    front_next            = front_reg + 1'b1;
                    word_next.mask[INDEX] = 1'b1;
                    word_next.count       = word_in.count + 7'd1;
                end
            end
            pnca_pkg::OP_READ:
            begin
                if (word_in.pos == pnca_pkg::POS_W'(INDEX))
                begin
                    word_next.front = front_ext[pnca_pkg::FVAL_W-1:0];
                end
            end
            default:
            begin
                word_next = word_in;
            end
        endcase
    end

    // Advance valid and front state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            front_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
            if (valid_in)
            begin
                front_reg <= front_next;
            end
        end
    end

    // Hold symbol and pass the word on
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
            if (valid_in)
            begin
                sym_reg <= sym_next;
            end
        end
    end

    assign valid_out = valid_reg;
    assign word_out  = word_reg;

endmodule

/* rtl/core/pattern_null_column_advance_core.sv */
// Path: an accepted word is registered in one head stage, then in each
// position cell in turn, and the last cell holds its result.
// Throughput: one word per cycle while the output is not held; words flow
// through the chain in order, so each cell sees every command in sequence.
// Reset: pattern length zero, all fronts zero, alphabet size 4, chain empty;
// pattern symbols are unspecified until appended.
// ============================================================================
// pattern_null_column_advance_core
// Pattern store with per-position front values, built as a chain of
// position cells fed by a command-checking head stage.
// ============================================================================
module pattern_null_column_advance_core #(
    parameter int MAX_PATTERN  = pnca_pkg::MAX_PATTERN_DEF,
    parameter int MAX_ALPHABET = pnca_pkg::MAX_ALPHABET_DEF,
    parameter int FRONT_BITS   = pnca_pkg::FRONT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [pnca_pkg::ALPHA_W-1:0]  cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pnca_pkg::CMD_W-1:0]    command,
    input  logic [pnca_pkg::SYM_W-1:0]    symbol,
    input  logic [pnca_pkg::DEPTH_W-1:0]  depth,
    input  logic [pnca_pkg::POS_W-1:0]    position,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pnca_pkg::STATUS_W-1:0] status,
    output logic [pnca_pkg::MASK_W-1:0]   advanced_mask,
    output logic [pnca_pkg::COUNT_W-1:0]  advanced_count,
    output logic [pnca_pkg::FVAL_W-1:0]   front_value,
    output logic [pnca_pkg::LEN_W-1:0]    pattern_length
);

    logic            en;
    logic            valid_s [0:MAX_PATTERN];
    pnca_pkg::word_t word_s  [0:MAX_PATTERN];

    // Move the whole chain unless the last result is held
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    pnca_head #(
        .MAX_PATTERN  (MAX_PATTERN),
        .MAX_ALPHABET (MAX_ALPHABET)
    ) u_head (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .command     (command),
        .symbol      (symbol),
        .depth       (depth),
        .position    (position),
        .valid_out   (valid_s[0]),
        .word_out    (word_s[0])
    );

    // One cell per pattern position
    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        pnca_cell #(
            .INDEX      (i),
            .FRONT_BITS (FRONT_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (valid_s[i]),
            .word_in   (word_s[i]),
            .valid_out (valid_s[i+1]),
            .word_out  (word_s[i+1])
        );
    end

    // Last cell is the output register
    assign out_valid      = valid_s[MAX_PATTERN];
    assign status         = word_s[MAX_PATTERN].status;
    assign advanced_mask  = word_s[MAX_PATTERN].mask;
    assign advanced_count = word_s[MAX_PATTERN].count;
    assign front_value    = word_s[MAX_PATTERN].front;
    assign pattern_length = word_s[MAX_PATTERN].length;

    // Count collected along the chain matches the mask bits set
    a_count_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (advanced_count == pnca_pkg::COUNT_W'($countones(advanced_mask))))
        else $error("advanced_count disagrees with advanced_mask");

    // Length never passes the pattern capacity
    a_length_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pattern_length <= pnca_pkg::LEN_W'(MAX_PATTERN)))
        else $error("pattern_length beyond capacity");

    // A rejected command leaves no trace in mask or front
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != pnca_pkg::ST_OK)) |->
            ((advanced_mask == '0) && (front_value == '0)))
        else $error("rejected word carries advance or read data");

endmodule
